[hw/rtl/pidpi_pkg.sv]
// ============================================================================
// pidpi_pkg
// Shared types, constants and arithmetic helpers of the PID controller.
// ============================================================================
`default_nettype none

package pidpi_pkg;

	localparam int DATA_W    = 32;
	localparam int GAIN_W    = 24;
	localparam int GAIN_FRAC = 16;
	localparam int BAND_W    = DATA_W - 1;
	localparam int CFG_IDX_W = 3;
	localparam int DIFF_W    = DATA_W + 3;
	localparam int SUM_W     = DATA_W + 2;
	localparam int PROD_W    = GAIN_W + DIFF_W;

	localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [BAND_W-1:0]        BAND_RESET = BAND_W'(1966080);

	typedef enum logic {
		OP_POSITIONAL  = 1'b0,
		OP_INCREMENTAL = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_P      = 3'd0,
		CFG_GAIN_I      = 3'd1,
		CFG_GAIN_D      = 3'd2,
		CFG_INTEG_UPPER = 3'd3,
		CFG_INTEG_LOWER = 3'd4,
		CFG_OUT_UPPER   = 3'd5,
		CFG_OUT_LOWER   = 3'd6,
		CFG_RESET_BAND  = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic signed [DATA_W-1:0] integ_upper;
		logic signed [DATA_W-1:0] integ_lower;
		logic signed [DATA_W-1:0] out_upper;
		logic signed [DATA_W-1:0] out_lower;
		logic [BAND_W-1:0]        reset_band;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		gain_p:      '0,
		gain_i:      '0,
		gain_d:      '0,
		integ_upper: DATA_MAX,
		integ_lower: DATA_MIN,
		out_upper:   DATA_MAX,
		out_lower:   DATA_MIN,
		reset_band:  BAND_RESET
	};

	typedef struct packed {
		opcode_t                  op;
		logic signed [DATA_W-1:0] prod_p;
		logic signed [DATA_W-1:0] prod_i;
		logic signed [DATA_W-1:0] prod_d;
		logic                     band_clear;
	} term_t;

	function automatic logic signed [DATA_W-1:0] sat_data(
		input logic signed [PROD_W-1:0] v
	);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		logic signed [DATA_W-1:0] r;
		hi = PROD_W'(DATA_MAX);
		lo = PROD_W'(DATA_MIN);
		if (v > hi) begin
			r = DATA_MAX;
		end else if (v < lo) begin
			r = DATA_MIN;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	// Product of a Q8.16 gain and an exact difference, floored and saturated.
	function automatic logic signed [DATA_W-1:0] gmul(
		input logic signed [GAIN_W-1:0] gain,
		input logic signed [DIFF_W-1:0] x
	);
		logic signed [PROD_W-1:0] p;
		p = PROD_W'(gain) * PROD_W'(x);
		return sat_data(p >>> GAIN_FRAC);
	endfunction

	// The upper test wins when the limits are crossed.
	function automatic logic signed [DATA_W-1:0] clamp_data(
		input logic signed [SUM_W-1:0]  v,
		input logic signed [DATA_W-1:0] upper,
		input logic signed [DATA_W-1:0] lower
	);
		logic signed [DATA_W-1:0] r;
		if (v > SUM_W'(upper)) begin
			r = upper;
		end else if (v < SUM_W'(lower)) begin
			r = lower;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/pidpi_cfg_regs.sv]
// ============================================================================
// pidpi_cfg_regs
// Configuration register file for gains, clamps and the integrator band.
// ============================================================================
`default_nettype none

module pidpi_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [pidpi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pidpi_pkg::DATA_W-1:0]     cfg_data,
	output pidpi_pkg::cfg_t                  cfg
);

	pidpi_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= pidpi_pkg::CFG_RESET;
		end else if (cfg_valid) begin
			unique case (pidpi_pkg::cfg_idx_t'(cfg_index))
				pidpi_pkg::CFG_GAIN_P: begin
					cfg_q.gain_p <= cfg_data[pidpi_pkg::GAIN_W-1:0];
				end
				pidpi_pkg::CFG_GAIN_I: begin
					cfg_q.gain_i <= cfg_data[pidpi_pkg::GAIN_W-1:0];
				end
				pidpi_pkg::CFG_GAIN_D: begin
					cfg_q.gain_d <= cfg_data[pidpi_pkg::GAIN_W-1:0];
				end
				pidpi_pkg::CFG_INTEG_UPPER: begin
					cfg_q.integ_upper <= cfg_data;
				end
				pidpi_pkg::CFG_INTEG_LOWER: begin
					cfg_q.integ_lower <= cfg_data;
				end
				pidpi_pkg::CFG_OUT_UPPER: begin
					cfg_q.out_upper <= cfg_data;
				end
				pidpi_pkg::CFG_OUT_LOWER: begin
					cfg_q.out_lower <= cfg_data;
				end
				pidpi_pkg::CFG_RESET_BAND: begin
					cfg_q.reset_band <= cfg_data[pidpi_pkg::BAND_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[hw/rtl/pidpi_front.sv]
// ============================================================================
// pidpi_front
// Error forming, error history and the three gain multiplies.
// ============================================================================
`default_nettype none

module pidpi_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pidpi_pkg::cfg_t                       cfg,
	input  pidpi_pkg::opcode_t                    op,
	input  logic signed [pidpi_pkg::DATA_W-1:0]   meas,
	input  logic signed [pidpi_pkg::DATA_W-1:0]   sp,
	input  logic                                  adv,
	output pidpi_pkg::term_t                      term
);

	logic signed [pidpi_pkg::DATA_W-1:0] prev_q;
	logic signed [pidpi_pkg::DATA_W-1:0] sprev_q;
	logic signed [pidpi_pkg::DATA_W-1:0] err_pos;
	logic signed [pidpi_pkg::DATA_W-1:0] err_new;
	logic signed [pidpi_pkg::DIFF_W-1:0] meas_x;
	logic signed [pidpi_pkg::DIFF_W-1:0] sp_x;
	logic signed [pidpi_pkg::DIFF_W-1:0] prev_x;
	logic signed [pidpi_pkg::DIFF_W-1:0] sprev_x;
	logic signed [pidpi_pkg::DIFF_W-1:0] band_x;
	logic signed [pidpi_pkg::DIFF_W-1:0] raw_err;
	logic signed [pidpi_pkg::DIFF_W-1:0] err_x;
	logic signed [pidpi_pkg::DIFF_W-1:0] bsum_lo;
	logic signed [pidpi_pkg::DIFF_W-1:0] bsum_hi;
	logic signed [pidpi_pkg::DIFF_W-1:0] opd_p;
	logic signed [pidpi_pkg::DIFF_W-1:0] opd_i;
	logic signed [pidpi_pkg::DIFF_W-1:0] opd_d;

	always_comb begin
		meas_x  = pidpi_pkg::DIFF_W'(meas);
		sp_x    = pidpi_pkg::DIFF_W'(sp);
		prev_x  = pidpi_pkg::DIFF_W'(prev_q);
		sprev_x = pidpi_pkg::DIFF_W'(sprev_q);
		band_x  = pidpi_pkg::DIFF_W'(cfg.reset_band);
		raw_err = meas_x - sp_x;
		err_pos = pidpi_pkg::sat_data(pidpi_pkg::PROD_W'(raw_err));
		err_x   = pidpi_pkg::DIFF_W'(err_pos);
		bsum_lo = err_x + sp_x + band_x;
		bsum_hi = err_x - sp_x - band_x;
		unique case (op)
			pidpi_pkg::OP_POSITIONAL: begin
				opd_p   = err_x;
				opd_i   = err_x;
				opd_d   = err_x - prev_x;
				err_new = err_pos;
			end
			pidpi_pkg::OP_INCREMENTAL: begin
				opd_p   = meas_x - prev_x;
				opd_i   = meas_x;
				opd_d   = meas_x - (prev_x <<< 1) + sprev_x;
				err_new = meas;
			end
			default: begin
				opd_p   = '0;
				opd_i   = '0;
				opd_d   = '0;
				err_new = '0;
			end
		endcase
		term.op         = op;
		term.prod_p     = pidpi_pkg::gmul(cfg.gain_p, opd_p);
		term.prod_i     = pidpi_pkg::gmul(cfg.gain_i, opd_i);
		term.prod_d     = pidpi_pkg::gmul(cfg.gain_d, opd_d);
		term.band_clear = (bsum_lo <= 0) || (bsum_hi >= 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			sprev_q <= '0;
		end else if (adv) begin
			prev_q <= err_new;
			if (op == pidpi_pkg::OP_INCREMENTAL) begin
				sprev_q <= prev_q;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/pidpi_back.sv]
// ============================================================================
// pidpi_back
// Integrator update, term sum and output clamp.
// ============================================================================
`default_nettype none

module pidpi_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pidpi_pkg::cfg_t                       cfg,
	input  pidpi_pkg::term_t                      term,
	input  logic                                  adv,
	output logic signed [pidpi_pkg::DATA_W-1:0]   y
);

	logic signed [pidpi_pkg::DATA_W-1:0] integ_q;
	logic signed [pidpi_pkg::DATA_W-1:0] integ_sat;
	logic signed [pidpi_pkg::DATA_W-1:0] integ_clamped;
	logic signed [pidpi_pkg::DATA_W-1:0] integ_new;
	logic signed [pidpi_pkg::SUM_W-1:0]  integ_sum;
	logic signed [pidpi_pkg::SUM_W-1:0]  y_sum;

	always_comb begin
		integ_sum     = pidpi_pkg::SUM_W'(integ_q) + pidpi_pkg::SUM_W'(term.prod_i);
		integ_sat     = pidpi_pkg::sat_data(pidpi_pkg::PROD_W'(integ_sum));
		integ_clamped = pidpi_pkg::clamp_data(pidpi_pkg::SUM_W'(integ_sat),
			cfg.integ_upper, cfg.integ_lower);
		integ_new     = term.band_clear ? '0 : integ_clamped;
		unique case (term.op)
			pidpi_pkg::OP_POSITIONAL: begin
				y_sum = pidpi_pkg::SUM_W'(term.prod_p) + pidpi_pkg::SUM_W'(integ_new)
					+ pidpi_pkg::SUM_W'(term.prod_d);
			end
			pidpi_pkg::OP_INCREMENTAL: begin
				y_sum = pidpi_pkg::SUM_W'(term.prod_p) + pidpi_pkg::SUM_W'(term.prod_i)
					+ pidpi_pkg::SUM_W'(term.prod_d);
			end
			default: begin
				y_sum = '0;
			end
		endcase
		y = pidpi_pkg::clamp_data(y_sum, cfg.out_upper, cfg.out_lower);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (adv && (term.op == pidpi_pkg::OP_POSITIONAL)) begin
			integ_q <= integ_new;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/pid_position_increment_controller.sv]
// ============================================================================
// pid_position_increment_controller
// Fixed-point PID controller with positional and incremental steps.
// ============================================================================
//
//  Channel   Handshake                Payload
//  input     in_valid / in_ready      opcode, measured, setpoint
//  result    out_valid / out_ready    control_out
//  config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A result is valid once its item has passed three registers. The item is
// loaded into the input register on the edge that accepts it, then into the
// multiply stage register and then the output register as each has room.
// One item is accepted every cycle unless stalled; the error history and,
// for positional items, the integrator update as an item leaves their stage.
// Reset clears all valid bits, the history and the integrator, and loads the
// register defaults. Empty stages close up while the result waits.
`default_nettype none

module pid_position_increment_controller (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  opcode,
	input  logic signed [pidpi_pkg::DATA_W-1:0]   measured,
	input  logic signed [pidpi_pkg::DATA_W-1:0]   setpoint,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [pidpi_pkg::DATA_W-1:0]   control_out,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pidpi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pidpi_pkg::DATA_W-1:0]          cfg_data
);

	pidpi_pkg::cfg_t                     cfg;
	pidpi_pkg::term_t                    term_d;
	pidpi_pkg::term_t                    term_s2;
	pidpi_pkg::opcode_t                  op_s1;
	logic signed [pidpi_pkg::DATA_W-1:0] meas_s1;
	logic signed [pidpi_pkg::DATA_W-1:0] sp_s1;
	logic signed [pidpi_pkg::DATA_W-1:0] y_d;
	logic signed [pidpi_pkg::DATA_W-1:0] ctrl_q;
	logic                                v_s1;
	logic                                v_s2;
	logic                                out_valid_q;
	logic                                en_out;
	logic                                en_s2;
	logic                                en_s1;

	assign en_out    = !out_valid_q || out_ready;
	assign en_s2     = !v_s2 || en_out;
	assign en_s1     = !v_s1 || en_s2;
	assign in_ready  = en_s1;
	assign cfg_ready = 1'b1;

	pidpi_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pidpi_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.op     (op_s1),
		.meas   (meas_s1),
		.sp     (sp_s1),
		.adv    (v_s1 && en_s2),
		.term   (term_d)
	);

	pidpi_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.term   (term_s2),
		.adv    (v_s2 && en_out),
		.y      (y_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_out) begin
				out_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && en_s1) begin
			op_s1   <= pidpi_pkg::opcode_t'(opcode);
			meas_s1 <= measured;
			sp_s1   <= setpoint;
		end
		if (v_s1 && en_s2) begin
			term_s2 <= term_d;
		end
		if (v_s2 && en_out) begin
			ctrl_q <= y_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign control_out = ctrl_q;

endmodule

`default_nettype wire

[hw/rtl/pidpi_checker.sv]
// ============================================================================
// pidpi_checker
// Port-level checks of the PID controller, bound to its top level.
// ============================================================================
`default_nettype none

module pidpi_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [pidpi_pkg::DATA_W-1:0]   control_out,
	input logic                                  cfg_ready
);

	// A stalled result keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(control_out))
		else $error("result changed while stalled");

	// With the output register empty the pipeline always has room.
	a_room_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// A draining output frees every stage behind it.
	a_room_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	// Configuration writes are never back-pressured.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid || !in_valid |-> cfg_ready)
		else $error("configuration port not ready");

endmodule

bind pid_position_increment_controller pidpi_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.control_out (control_out),
	.cfg_ready   (cfg_ready)
);

`default_nettype wire

[dv/tb_pid_position_increment_controller.sv]
// ----------------------------------------------------------------------------
// Testbench for pid_position_increment_controller
//
// A directed table covers the register defaults after reset, gain and data
// extremes, saturation of a wide error, crossed integrator and output limits
// and the integrator band. Random phases with new register settings follow.
// Each accepted item is run through a bit-accurate predictor, and every
// result is compared with the oldest expected value. Both channels idle and
// stall at random, including a long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb_pid_position_increment_controller;
	timeunit 1ns;
	timeprecision 1ps;

	import pidpi_pkg::*;

	localparam int CYCLE_LIMIT     = 300000;
	localparam int RAND_PHASES     = 14;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int HOLD_CYCLES     = 80;
	localparam int TAIL_CYCLES     = 8;

	localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

	typedef struct {
		bit                       is_write;
		cfg_idx_t                 idx;
		logic [DATA_W-1:0]        wdata;
		opcode_t                  op;
		logic signed [DATA_W-1:0] meas;
		logic signed [DATA_W-1:0] sp;
		bit                       has_exp;
		logic signed [DATA_W-1:0] exp_out;
	} stim_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic                     opcode;
	logic signed [DATA_W-1:0] measured;
	logic signed [DATA_W-1:0] setpoint;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [DATA_W-1:0] control_out;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [DATA_W-1:0]        cfg_data;

	logic signed [DATA_W-1:0] expected_control[$];
	stim_row_t                directed_rows[$];
	logic signed [DATA_W-1:0] want_out;

	longint k_p, k_i, k_d;
	longint integ_hi, integ_lo, out_hi, out_lo, band_half;
	longint integ_acc, err_z1, err_z2;

	int  error_count;
	int  results_checked;
	int  positional_sent;
	int  incremental_sent;
	int  settings_used;
	int  cycle_count;
	bit  calm;
	bit  hold_req;

	pid_position_increment_controller dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.measured    (measured),
		.setpoint    (setpoint),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.control_out (control_out),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic longint saturate_data(longint v);
		if (v > longint'(DATA_MAX)) begin
			return longint'(DATA_MAX);
		end else if (v < longint'(DATA_MIN)) begin
			return longint'(DATA_MIN);
		end
		return v;
	endfunction

	function automatic longint gain_product(longint g, longint x);
		longint p;
		p = (g * x) >>> GAIN_FRAC;
		return saturate_data(p);
	endfunction

	function automatic longint clamp_window(longint v, longint upper, longint lower);
		if (v > upper) begin
			return upper;
		end else if (v < lower) begin
			return lower;
		end
		return v;
	endfunction

	function automatic void apply_setting(cfg_idx_t idx, logic [DATA_W-1:0] d);
		case (idx)
			CFG_GAIN_P:      k_p = longint'($signed(d[GAIN_W-1:0]));
			CFG_GAIN_I:      k_i = longint'($signed(d[GAIN_W-1:0]));
			CFG_GAIN_D:      k_d = longint'($signed(d[GAIN_W-1:0]));
			CFG_INTEG_UPPER: integ_hi = longint'($signed(d));
			CFG_INTEG_LOWER: integ_lo = longint'($signed(d));
			CFG_OUT_UPPER:   out_hi = longint'($signed(d));
			CFG_OUT_LOWER:   out_lo = longint'($signed(d));
			CFG_RESET_BAND:  band_half = longint'(d[BAND_W-1:0]);
			default: ;
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] predict_control(
		opcode_t op,
		logic signed [DATA_W-1:0] m,
		logic signed [DATA_W-1:0] s
	);
		longint meas_v, sp_v, err, y;
		meas_v = m;
		sp_v = s;
		if (op == OP_POSITIONAL) begin
			err = saturate_data(meas_v - sp_v);
			integ_acc = clamp_window(saturate_data(integ_acc + gain_product(k_i, err)),
				integ_hi, integ_lo);
			if (err <= -band_half - sp_v || err >= band_half + sp_v) begin
				integ_acc = 0;
			end
			y = gain_product(k_p, err) + integ_acc + gain_product(k_d, err - err_z1);
			err_z1 = err;
		end else begin
			err = meas_v;
			y = gain_product(k_p, err - err_z1) + gain_product(k_i, err)
				+ gain_product(k_d, err - 2 * err_z1 + err_z2);
			err_z2 = err_z1;
			err_z1 = err;
		end
		y = clamp_window(y, out_hi, out_lo);
		return y[DATA_W-1:0];
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_data();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(4))
					0: return DATA_MAX;
					1: return DATA_MIN;
					2: return 0;
					3: return -1;
					default: return 1;
				endcase
			end
			1, 2: return $urandom;
			default: return int'($urandom_range(0, 1 << 23)) - (1 << 22);
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] rand_gain();
		logic [DATA_W-1:0] junk;
		junk = $urandom & 32'hFF00_0000;
		case ($urandom_range(7))
			0: return junk | 32'h007F_FFFF;
			1: return junk | 32'h0080_0000;
			2: return junk;
			3: return $urandom;
			default: return junk | {8'h00, 24'(int'($urandom_range(0, 6 << 16)) - (3 << 16))};
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] rand_band();
		case ($urandom_range(5))
			0: return 0;
			1: return 32'h7FFF_FFFF;
			2: return 32'(BAND_RESET);
			3: return $urandom;
			default: return $urandom_range(0, 1 << 22);
		endcase
	endfunction

	task automatic pick_limits(output logic [DATA_W-1:0] upper, output logic [DATA_W-1:0] lower);
		int span;
		span = $urandom_range(1, 1 << 22);
		case ($urandom_range(4))
			0: begin
				upper = DATA_MAX;
				lower = DATA_MIN;
			end
			1: begin
				upper = $urandom;
				lower = $urandom;
			end
			2: begin
				upper = span;
				lower = -span;
			end
			3: begin
				upper = -span;
				lower = span;
			end
			default: begin
				upper = $urandom_range(0, 1 << 24);
				lower = upper - $urandom_range(0, 1 << 25);
			end
		endcase
	endtask

	task automatic row_write(cfg_idx_t idx, logic [DATA_W-1:0] d);
		stim_row_t r;
		r = '{is_write: 1'b1, idx: idx, wdata: d, op: OP_POSITIONAL, meas: 0, sp: 0,
			has_exp: 1'b0, exp_out: 0};
		directed_rows.push_back(r);
	endtask

	task automatic row_item(opcode_t op, logic signed [DATA_W-1:0] m,
		logic signed [DATA_W-1:0] s, bit has_exp, logic signed [DATA_W-1:0] e);
		stim_row_t r;
		r = '{is_write: 1'b0, idx: CFG_GAIN_P, wdata: 0, op: op, meas: m, sp: s,
			has_exp: has_exp, exp_out: e};
		directed_rows.push_back(r);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_control.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [DATA_W-1:0] d);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		apply_setting(idx, d);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_item(opcode_t op, logic signed [DATA_W-1:0] m,
		logic signed [DATA_W-1:0] s, bit has_exp, logic signed [DATA_W-1:0] e);
		logic signed [DATA_W-1:0] predicted;
		@(negedge clk);
		while (!calm && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		measured <= m;
		setpoint <= s;
		do @(posedge clk); while (!in_ready);
		predicted = predict_control(op, m, s);
		expected_control.push_back(has_exp ? e : predicted);
		if (op == OP_POSITIONAL) begin
			positional_sent++;
		end else begin
			incremental_sent++;
		end
	endtask

	task automatic randomize_setting(int phase);
		logic [DATA_W-1:0] upper, lower;
		settings_used++;
		if (phase == 0) begin
			write_reg(CFG_GAIN_P, 32'h007F_FFFF);
			write_reg(CFG_GAIN_I, 32'h007F_FFFF);
			write_reg(CFG_GAIN_D, 32'h007F_FFFF);
		end else if (phase == 1) begin
			write_reg(CFG_GAIN_P, 32'h0080_0000);
			write_reg(CFG_GAIN_I, 32'h0080_0000);
			write_reg(CFG_GAIN_D, 32'h0080_0000);
		end else begin
			write_reg(CFG_GAIN_P, rand_gain());
			write_reg(CFG_GAIN_I, rand_gain());
			write_reg(CFG_GAIN_D, rand_gain());
		end
		pick_limits(upper, lower);
		write_reg(CFG_INTEG_UPPER, upper);
		write_reg(CFG_INTEG_LOWER, lower);
		pick_limits(upper, lower);
		write_reg(CFG_OUT_UPPER, upper);
		write_reg(CFG_OUT_LOWER, lower);
		write_reg(CFG_RESET_BAND, (phase == 1) ? 32'h0 : rand_band());
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 17);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_control.size() == 0) begin
				$display("%0t: unexpected result, expected none, got control_out %0d",
					$time, control_out);
				error_count++;
			end else begin
				want_out = expected_control.pop_front();
				results_checked++;
				if (control_out !== want_out) begin
					$display("%0t: control_out mismatch, expected %0d, got %0d",
						$time, want_out, control_out);
					error_count++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles, %0d results outstanding",
			$time, cycle_count, expected_control.size());
		$display("pid_position_increment_controller regression: fail");
		$finish;
	end

	initial begin
		int phase, n, total_n, inc_share;
		opcode_t op;

		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = 1'b0;
		measured = '0;
		setpoint = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		error_count = 0;
		results_checked = 0;
		positional_sent = 0;
		incremental_sent = 0;
		settings_used = 1;
		k_p = 0;
		k_i = 0;
		k_d = 0;
		integ_hi = longint'(DATA_MAX);
		integ_lo = longint'(DATA_MIN);
		out_hi = longint'(DATA_MAX);
		out_lo = longint'(DATA_MIN);
		band_half = longint'(BAND_RESET);
		integ_acc = 0;
		err_z1 = 0;
		err_z2 = 0;

		// With all gains at zero after reset, every result is zero.
		row_item(OP_POSITIONAL, DATA_MAX, DATA_MIN, 1'b1, 0);
		row_item(OP_POSITIONAL, DATA_MIN, DATA_MAX, 1'b1, 0);
		row_item(OP_INCREMENTAL, DATA_MAX, 0, 1'b1, 0);
		row_item(OP_INCREMENTAL, DATA_MIN, DATA_MAX, 1'b1, 0);
		row_write(CFG_GAIN_P, Q_ONE);
		row_item(OP_POSITIONAL, 5 * Q_ONE, 2 * Q_ONE, 1'b1, 3 * Q_ONE);
		row_item(OP_POSITIONAL, DATA_MAX, DATA_MIN, 1'b1, DATA_MAX);
		row_item(OP_POSITIONAL, DATA_MIN, DATA_MAX, 1'b1, DATA_MIN);
		row_item(OP_POSITIONAL, 0, 0, 1'b1, 0);
		row_item(OP_INCREMENTAL, 7 * Q_ONE, 0, 1'b1, 7 * Q_ONE);
		row_item(OP_INCREMENTAL, -1, DATA_MIN, 1'b0, 0);
		row_write(CFG_GAIN_P, 32'h007F_FFFF);
		row_write(CFG_GAIN_I, 32'h0080_0000);
		row_write(CFG_GAIN_D, 32'h007F_FFFF);
		row_item(OP_POSITIONAL, DATA_MAX, DATA_MIN, 1'b0, 0);
		row_item(OP_POSITIONAL, DATA_MIN, DATA_MAX, 1'b0, 0);
		row_item(OP_INCREMENTAL, DATA_MAX, 0, 1'b0, 0);
		row_item(OP_INCREMENTAL, DATA_MIN, 0, 1'b0, 0);
		row_item(OP_INCREMENTAL, DATA_MAX, 0, 1'b0, 0);
		row_item(OP_POSITIONAL, -1, 1, 1'b0, 0);
		row_write(CFG_GAIN_P, 32'h0);
		row_write(CFG_GAIN_I, 32'h0);
		row_write(CFG_GAIN_D, 32'h0);
		row_write(CFG_OUT_UPPER, -100);
		row_write(CFG_OUT_LOWER, 100);
		row_item(OP_INCREMENTAL, 12345, 0, 1'b1, -100);
		row_item(OP_INCREMENTAL, DATA_MIN, 0, 1'b1, -100);
		row_item(OP_POSITIONAL, 3 * Q_ONE, Q_ONE, 1'b0, 0);
		row_write(CFG_OUT_UPPER, DATA_MAX);
		row_write(CFG_OUT_LOWER, DATA_MIN);
		row_write(CFG_INTEG_UPPER, -5 * Q_ONE);
		row_write(CFG_INTEG_LOWER, 5 * Q_ONE);
		row_write(CFG_GAIN_I, Q_ONE);
		row_write(CFG_RESET_BAND, 32'h7FFF_FFFF);
		row_item(OP_POSITIONAL, 3 * Q_ONE, 0, 1'b0, 0);
		row_item(OP_POSITIONAL, -2 * Q_ONE, 0, 1'b0, 0);
		row_item(OP_POSITIONAL, 10 * Q_ONE, 0, 1'b0, 0);
		row_write(CFG_RESET_BAND, 32'h0);
		row_item(OP_POSITIONAL, Q_ONE, 2 * Q_ONE, 1'b0, 0);
		row_item(OP_POSITIONAL, -Q_ONE, -3 * Q_ONE, 1'b0, 0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_write) begin
				write_reg(directed_rows[i].idx, directed_rows[i].wdata);
			end else begin
				send_item(directed_rows[i].op, directed_rows[i].meas, directed_rows[i].sp,
					directed_rows[i].has_exp, directed_rows[i].exp_out);
			end
		end

		for (phase = 0; phase < RAND_PHASES; phase++) begin
			randomize_setting(phase);
			inc_share = $urandom_range(0, 100);
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				total_n = phase * ITEMS_PER_PHASE + n;
				calm = (total_n >= 500 && total_n < 800);
				if (total_n == 300 || total_n == 1000) begin
					hold_req = 1'b1;
				end
				if (total_n == 350 || total_n == 1150) begin
					drain_results();
				end
				op = ($urandom_range(99) < inc_share) ? OP_INCREMENTAL : OP_POSITIONAL;
				send_item(op, rand_data(), rand_data(), 1'b0, 0);
			end
		end
		calm = 1'b0;

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d results from %0d positional and %0d incremental items",
			results_checked, positional_sent, incremental_sent);
		$display("across %0d register settings, with %0d errors.", settings_used, error_count);
		if (error_count == 0) begin
			$display("pid_position_increment_controller regression: pass");
		end else begin
			$display("pid_position_increment_controller regression: fail");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/pidpi_pkg.sv
hw/rtl/pidpi_cfg_regs.sv
hw/rtl/pidpi_front.sv
hw/rtl/pidpi_back.sv
hw/rtl/pid_position_increment_controller.sv
hw/rtl/pidpi_checker.sv
dv/tb_pid_position_increment_controller.sv
